[design/tdl_pkg.sv]
// ----------------------------------------------------------------------------
// tdl_pkg
// Shared constants and types of the token lexer: result codes, token
// classes, input modes and the result group passed from lexer to output.
// ----------------------------------------------------------------------------
package tdl_pkg;

  // Field widths of the result item.
  localparam int COL_W = 10;
  localparam int ROW_W = 16;
  localparam int LEN_W = 8;

  // Limits of the counters.
  localparam int MAX_COLUMNS      = 1024;
  localparam int MAX_ROWS         = 65536;
  localparam int MAX_TOKEN_LENGTH = 255;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_TOKEN_LENGTH);

  // Results caused by one input item.
  localparam int MAX_RES   = 4;
  localparam int RES_IDX_W = $clog2(MAX_RES);
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);

  // Queue between the lexer and the output serializer, in result groups.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int OUT_DATA_W = 48;

  // Input modes.
  localparam logic [1:0] MODE_CHAR    = 2'd0;
  localparam logic [1:0] MODE_EOL     = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_TOKEN = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Token classes.
  localparam logic [2:0] CLS_WORD     = 3'd0;
  localparam logic [2:0] CLS_NUMBER   = 3'd1;
  localparam logic [2:0] CLS_STRING   = 3'd2;
  localparam logic [2:0] CLS_PUNCT    = 3'd3;
  localparam logic [2:0] CLS_ELLIPSIS = 3'd4;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data_byte;
    logic [2:0]       cls;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [LEN_W-1:0] len;
  } tdl_result_t;

  typedef struct packed {
    tdl_result_t [MAX_RES-1:0] res;
    logic [RES_CNT_W-1:0]      count;
  } tdl_group_t;

endpackage

[design/tdl_front.sv]
// ----------------------------------------------------------------------------
// tdl_front
// Lexer automaton: accepts one input item a cycle unless the queue is full,
// updates the lexer state and groups the item's results for the queue.
// ----------------------------------------------------------------------------
module tdl_front import tdl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // char_byte[7:0]
  input  logic [1:0] s_tuser,   // mode[1:0]
  input  logic       q_full,
  output logic       push,
  output tdl_group_t push_group
);

  typedef enum logic [8:0] {
    LX_START   = 9'b000000001,
    LX_COMMENT = 9'b000000010,
    LX_WORD    = 9'b000000100,
    LX_NUMBER  = 9'b000001000,
    LX_NUMDOT  = 9'b000010000,
    LX_STRING  = 9'b000100000,
    LX_ESCAPE  = 9'b001000000,
    LX_DOT     = 9'b010000000,
    LX_ELL2    = 9'b100000000
  } lx_state_t;

  typedef struct packed {
    lx_state_t        state;
    logic [COL_W-1:0] start_col;
    logic [LEN_W-1:0] char_count;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             locked;
  } lx_core_t;

  typedef struct packed {
    lx_core_t   core;
    tdl_group_t grp;
  } lx_ctx_t;

  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_EQUAL     = 8'h3D;
  localparam logic [7:0] CH_UP_A      = 8'h41;
  localparam logic [7:0] CH_UP_E      = 8'h45;
  localparam logic [7:0] CH_UP_Z      = 8'h5A;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_UNDERLINE = 8'h5F;
  localparam logic [7:0] CH_LO_A      = 8'h61;
  localparam logic [7:0] CH_LO_E      = 8'h65;
  localparam logic [7:0] CH_LO_Z      = 8'h7A;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;

  function automatic lx_core_t core_reset();
    lx_core_t r;
    r.state      = LX_START;
    r.start_col  = '0;
    r.char_count = '0;
    r.column     = '0;
    r.row        = '0;
    r.locked     = 1'b0;
    return r;
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return c == CH_LBRACKET || c == CH_RBRACKET || c == CH_LBRACE ||
           c == CH_RBRACE || c == CH_EQUAL || c == CH_COMMA;
  endfunction

  function automatic logic is_ident(logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           c == CH_DOLLAR || c == CH_UNDERLINE;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic lx_ctx_t put_res(lx_ctx_t x, logic [1:0] kind, logic [7:0] data,
                                      logic [2:0] cls, logic [ROW_W-1:0] row,
                                      logic [COL_W-1:0] col, logic [LEN_W-1:0] len);
    lx_ctx_t     y;
    tdl_result_t r;
    y = x;
    r.kind      = kind;
    r.data_byte = data;
    r.cls       = cls;
    r.row       = row;
    r.col       = col;
    r.len       = len;
    if (x.grp.count < RES_CNT_W'(MAX_RES)) begin
      y.grp.res[x.grp.count[RES_IDX_W-1:0]] = r;
      y.grp.count = x.grp.count + RES_CNT_W'(1);
    end
    return y;
  endfunction

  function automatic lx_ctx_t raise_error(lx_ctx_t x);
    lx_ctx_t y;
    y = x;
    if (!x.core.locked) begin
      y = put_res(y, KIND_ERROR, 8'd0, 3'd0, x.core.row, x.core.column, '0);
      y.core.locked = 1'b1;
    end
    return y;
  endfunction

  function automatic lx_ctx_t append_char(lx_ctx_t x, logic [7:0] c);
    lx_ctx_t y;
    y = x;
    if (!x.core.locked) begin
      if (x.core.char_count >= LEN_MAX) begin
        y = raise_error(y);
      end else begin
        if (x.core.char_count == '0) y.core.start_col = x.core.column;
        y.core.char_count = x.core.char_count + LEN_W'(1);
        y = put_res(y, KIND_CHAR, c, 3'd0, '0, '0, '0);
      end
    end
    return y;
  endfunction

  function automatic lx_ctx_t emit_token(lx_ctx_t x, logic [2:0] cls);
    lx_ctx_t y;
    y = x;
    if (!x.core.locked) begin
      y = put_res(y, KIND_TOKEN, 8'd0, cls, x.core.row, x.core.start_col,
                  x.core.char_count);
      y.core.char_count = '0;
    end
    return y;
  endfunction

  // The number loses its trailing dot, which then starts the next token.
  function automatic lx_ctx_t split_last(lx_ctx_t x);
    lx_ctx_t          y;
    logic [LEN_W-1:0] first;
    y = x;
    first = x.core.char_count - LEN_W'(1);
    if (!x.core.locked && x.core.char_count != '0) begin
      y = put_res(y, KIND_TOKEN, 8'd0, CLS_NUMBER, x.core.row, x.core.start_col, first);
      y.core.start_col  = x.core.start_col + COL_W'(first);
      y.core.char_count = LEN_W'(1);
    end
    return y;
  endfunction

  function automatic lx_ctx_t lex_char(lx_ctx_t x, logic [7:0] c);
    lx_ctx_t y;
    logic    sign;
    logic    num_ch;
    y = x;
    sign   = c == CH_PLUS || c == CH_MINUS;
    num_ch = sign || c == CH_LO_E || c == CH_UP_E || is_digit(c);
    if (!x.core.locked) begin
      unique case (x.core.state)
        LX_START: begin
          if (c == CH_SPACE) begin
            y = x;
          end else if (c == CH_QUOTE) begin
            y = append_char(y, c);
            y.core.state = LX_STRING;
          end else if (c == CH_HASH) begin
            y.core.state = LX_COMMENT;
          end else if (sign || is_digit(c)) begin
            y = append_char(y, c);
            y.core.state = LX_NUMBER;
          end else if (c == CH_DOT) begin
            y = append_char(y, c);
            y.core.state = LX_DOT;
          end else if (is_punct(c)) begin
            y = emit_token(append_char(y, c), CLS_PUNCT);
            y.core.state = LX_START;
          end else if (is_ident(c)) begin
            y = append_char(y, c);
            y.core.state = LX_WORD;
          end else begin
            y = raise_error(y);
          end
        end
        LX_COMMENT: begin
          y = x;
        end
        LX_WORD: begin
          if (is_ident(c) || is_digit(c)) begin
            y = append_char(y, c);
          end else if (c == CH_SPACE) begin
            y = emit_token(y, CLS_WORD);
            y.core.state = LX_START;
          end else if (c == CH_HASH) begin
            y = emit_token(y, CLS_WORD);
            y.core.state = LX_COMMENT;
          end else if (c == CH_QUOTE) begin
            y = append_char(emit_token(y, CLS_WORD), c);
            y.core.state = LX_STRING;
          end else if (sign) begin
            y = append_char(emit_token(y, CLS_WORD), c);
            y.core.state = LX_NUMBER;
          end else if (c == CH_DOT) begin
            y = append_char(emit_token(y, CLS_WORD), c);
            y.core.state = LX_DOT;
          end else if (is_punct(c)) begin
            y = emit_token(append_char(emit_token(y, CLS_WORD), c), CLS_PUNCT);
            y.core.state = LX_START;
          end else begin
            y = raise_error(y);
          end
        end
        LX_NUMBER, LX_NUMDOT, LX_DOT: begin
          if (num_ch) begin
            y = append_char(y, c);
            y.core.state = LX_NUMBER;
          end else if (c == CH_HASH) begin
            y = emit_token(y, CLS_NUMBER);
            y.core.state = LX_COMMENT;
          end else if (c == CH_QUOTE) begin
            // After a number ending in a dot the opening quote is not kept.
            y = emit_token(y, CLS_NUMBER);
            if (x.core.state != LX_NUMDOT) y = append_char(y, c);
            y.core.state = LX_STRING;
          end else if (c == CH_SPACE) begin
            y = emit_token(y, CLS_NUMBER);
            y.core.state = LX_START;
          end else if (is_ident(c)) begin
            y = append_char(emit_token(y, CLS_NUMBER), c);
            y.core.state = LX_WORD;
          end else if (c == CH_DOT) begin
            if (x.core.state == LX_NUMBER) begin
              y = append_char(y, c);
              y.core.state = LX_NUMDOT;
            end else begin
              if (x.core.state == LX_NUMDOT) y = split_last(y);
              y = append_char(y, c);
              y.core.state = LX_ELL2;
            end
          end else if (is_punct(c)) begin
            y = emit_token(append_char(emit_token(y, CLS_NUMBER), c), CLS_PUNCT);
            y.core.state = LX_START;
          end else begin
            y = raise_error(y);
          end
        end
        LX_ELL2: begin
          if (c == CH_DOT) begin
            y = emit_token(append_char(y, c), CLS_ELLIPSIS);
            y.core.state = LX_START;
          end else begin
            y = raise_error(y);
          end
        end
        LX_STRING: begin
          if (c == CH_QUOTE) begin
            y = emit_token(append_char(y, c), CLS_STRING);
            y.core.state = LX_START;
          end else if (c == CH_BACKSLASH) begin
            y.core.state = LX_ESCAPE;
          end else begin
            y = append_char(y, c);
          end
        end
        LX_ESCAPE: begin
          if (c == CH_QUOTE || c == CH_BACKSLASH) begin
            y = append_char(y, c);
            y.core.state = LX_STRING;
          end else begin
            y = raise_error(y);
          end
        end
        default: begin
          y = raise_error(y);
        end
      endcase
      if (y.core.column != COL_LAST) y.core.column = y.core.column + COL_W'(1);
    end
    return y;
  endfunction

  function automatic lx_ctx_t end_of_line(lx_ctx_t x);
    lx_ctx_t y;
    y = x;
    if (x.core.state == LX_STRING || x.core.state == LX_ESCAPE ||
        x.core.state == LX_ELL2) begin
      y = raise_error(y);
    end else begin
      if (x.core.char_count != '0) begin
        y = emit_token(y, (x.core.state == LX_WORD) ? CLS_WORD : CLS_NUMBER);
      end
      if (!y.core.locked) begin
        y.core.state      = LX_START;
        y.core.char_count = '0;
        y.core.start_col  = '0;
        y.core.column     = '0;
        y.core.row        = (x.core.row == ROW_LAST) ? '0 : x.core.row + ROW_W'(1);
      end
    end
    return y;
  endfunction

  lx_core_t core;
  lx_core_t core_next;
  lx_ctx_t  ctx;
  logic     accept;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    ctx.core = core;
    ctx.grp  = '0;
    unique case (s_tuser)
      MODE_RESTART: begin
        ctx.core = core_reset();
      end
      MODE_EOL: begin
        if (!core.locked) ctx = end_of_line(ctx);
      end
      MODE_CHAR: begin
        if (!core.locked) begin
          if (s_tdata[7]) begin
            ctx = raise_error(ctx);
          end else if (s_tdata == CH_TAB) begin
            // A tab is four spaces, each stepping the automaton once.
            ctx = lex_char(lex_char(lex_char(lex_char(ctx, CH_SPACE), CH_SPACE),
                                    CH_SPACE), CH_SPACE);
          end else if (s_tdata >= CH_SPACE) begin
            ctx = lex_char(ctx, s_tdata);
          end
        end
      end
      default: begin
        ctx.core = core;
      end
    endcase
    core_next = ctx.core;
  end

  assign push       = accept && (ctx.grp.count != '0);
  assign push_group = ctx.grp;

  always_ff @(posedge clk) begin
    if (rst) begin
      core <= core_reset();
    end else if (accept) begin
      core <= core_next;
    end
  end

endmodule

[design/tdl_queue.sv]
// ----------------------------------------------------------------------------
// tdl_queue
// Short FIFO of result groups between the lexer and the output serializer.
// ----------------------------------------------------------------------------
module tdl_queue import tdl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  tdl_group_t push_group,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output tdl_group_t head_group
);

  tdl_group_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full       = fill == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = fill != '0;
  assign head_group = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_group;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

[design/tdl_back.sv]
// ----------------------------------------------------------------------------
// tdl_back
// Output serializer: sends the results of the head group one item at a
// time and marks the final one of each group.
// ----------------------------------------------------------------------------
module tdl_back import tdl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  tdl_group_t            head_group,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_byte[7:0], token_class[10:8], row_number[26:11], column_number[36:27],
  // token_length[44:37], zero fill[47:45]
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [1:0]            m_tuser,   // kind[1:0]
  output logic                  m_tlast
);

  logic [RES_IDX_W-1:0] idx;
  tdl_result_t          cur;
  logic                 fire;
  logic                 final_res;

  assign cur       = head_group.res[idx];
  assign final_res = (RES_CNT_W'(idx) + RES_CNT_W'(1)) == head_group.count;
  assign fire      = head_valid && m_tready;
  assign pop       = fire && final_res;

  assign m_tvalid = head_valid;
  assign m_tuser  = cur.kind;
  assign m_tlast  = final_res;
  assign m_tdata  = {(OUT_DATA_W - 45)'(0), cur.len, cur.col, cur.row, cur.cls,
                     cur.data_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (fire) begin
      idx <= final_res ? '0 : idx + RES_IDX_W'(1);
    end
  end

endmodule

[design/table_driven_token_lexer.sv]
// ----------------------------------------------------------------------------
// table_driven_token_lexer
// Streaming lexer: one character, line end or restart event per item in, a stream of
// appended characters, completed tokens and syntax errors out.
// ----------------------------------------------------------------------------
// An accepted item's result group is registered in the queue and offered from its head.
// Throughput: one item per cycle while the queue is not full; the output port sends
// one result per cycle when m_tready is high; an item yields at most 4 results.
// A four-group queue between the automaton and the output absorbs such bursts.
// Reset: synchronous rst returns the lexer to its start state at row 0 and
// empties the queue; the block accepts items in the next cycle.
module table_driven_token_lexer import tdl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // char_byte[7:0]
  input  logic [1:0]            s_tuser,   // mode[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_byte[7:0], token_class[10:8], row_number[26:11], column_number[36:27],
  // token_length[44:37], zero fill[47:45]
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [1:0]            m_tuser,   // kind[1:0]
  output logic                  m_tlast
);

  logic       q_full;
  logic       push;
  tdl_group_t push_group;
  logic       pop;
  logic       head_valid;
  tdl_group_t head_group;

  tdl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .q_full     (q_full),
    .push       (push),
    .push_group (push_group)
  );

  tdl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_group (head_group)
  );

  tdl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_group (head_group),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

[sim/tb_table_driven_token_lexer.sv]
// ----------------------------------------------------------------------------
// tb_table_driven_token_lexer
// Self-checking bench for the streaming token lexer. A scoreboard class
// predicts the character, token and error results of every accepted item and
// checks them in order against the output stream. Directed items cover the
// token transitions, then random token sequences with noise run under random
// sender gaps and receiver stalls, followed by strings at and just past the
// longest token.
// ----------------------------------------------------------------------------
module tb_table_driven_token_lexer import tdl_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_GOAL = 340;
  localparam int LONG_HOLD   = 300;

  typedef enum logic [3:0] {
    ST_START, ST_COMMENT, ST_WORD, ST_NUMBER, ST_NUMDOT,
    ST_STRING, ST_ESCAPE, ST_DOT, ST_ELL2
  } lex_state_t;

  typedef struct packed {
    tdl_result_t res;
    logic        last;
  } lex_item_t;

  class lexer_scoreboard;
    lex_state_t state;
    int         tok_col;
    int         tok_cnt;
    int         cur_col;
    int         cur_row;
    bit         locked;
    lex_item_t  step_res [MAX_RES];
    int         step_n;
    lex_item_t  expect_q [$];
    int         mismatches;

    function new();
      reset_state();
      mismatches = 0;
    endfunction

    function void reset_state();
      state   = ST_START;
      tok_col = 0;
      tok_cnt = 0;
      cur_col = 0;
      cur_row = 0;
      locked  = 1'b0;
    endfunction

    function int pending();
      return expect_q.size();
    endfunction

    function bit is_locked();
      return locked;
    endfunction

    function void put(logic [1:0] kind, logic [7:0] b, logic [2:0] cls,
                      int row, int col, int len);
      lex_item_t r;
      if (step_n >= MAX_RES) return;
      r.res.kind      = kind;
      r.res.data_byte = b;
      r.res.cls       = cls;
      r.res.row       = ROW_W'(row);
      r.res.col       = COL_W'(col);
      r.res.len       = LEN_W'(len);
      r.last          = 1'b0;
      step_res[step_n] = r;
      step_n++;
    endfunction

    function void raise_err();
      if (locked) return;
      put(KIND_ERROR, 8'h00, 3'd0, cur_row, cur_col, 0);
      locked = 1'b1;
    endfunction

    function void append(logic [7:0] c);
      if (locked) return;
      if (tok_cnt >= MAX_TOKEN_LENGTH) begin
        raise_err();
        return;
      end
      if (tok_cnt == 0) tok_col = cur_col;
      tok_cnt++;
      put(KIND_CHAR, c, 3'd0, 0, 0, 0);
    endfunction

    function void emit(logic [2:0] cls);
      if (locked) return;
      put(KIND_TOKEN, 8'h00, cls, cur_row, tok_col, tok_cnt);
      tok_cnt = 0;
    endfunction

    // A number ending in a dot loses that dot to the ellipsis that follows.
    function void split_last();
      int first;
      if (locked || tok_cnt == 0) return;
      first = tok_cnt - 1;
      put(KIND_TOKEN, 8'h00, CLS_NUMBER, cur_row, tok_col, first);
      tok_col += first;
      tok_cnt = 1;
    endfunction

    function bit is_punct(logic [7:0] c);
      return c inside {"[", "]", "{", "}", "=", ","};
    endfunction

    function bit is_ident(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "$" || c == "_";
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function void lex_char(logic [7:0] c);
      lex_state_t s;
      bit sign;
      bit expo;
      if (locked) return;
      s    = state;
      sign = (c == "+" || c == "-");
      expo = (c == "e" || c == "E");
      case (s)
        ST_START: begin
          if (c == CH_SPACE) begin
          end else if (c == CH_QUOTE) begin
            append(c);
            state = ST_STRING;
          end else if (c == CH_HASH) begin
            state = ST_COMMENT;
          end else if (sign || is_digit(c)) begin
            append(c);
            state = ST_NUMBER;
          end else if (c == CH_DOT) begin
            append(c);
            state = ST_DOT;
          end else if (is_punct(c)) begin
            append(c);
            emit(CLS_PUNCT);
            state = ST_START;
          end else if (is_ident(c)) begin
            append(c);
            state = ST_WORD;
          end else begin
            raise_err();
          end
        end
        ST_COMMENT: begin
        end
        ST_WORD: begin
          if (is_ident(c) || is_digit(c)) begin
            append(c);
          end else if (c == CH_SPACE) begin
            emit(CLS_WORD);
            state = ST_START;
          end else if (c == CH_HASH) begin
            emit(CLS_WORD);
            state = ST_COMMENT;
          end else if (c == CH_QUOTE) begin
            emit(CLS_WORD);
            append(c);
            state = ST_STRING;
          end else if (sign) begin
            emit(CLS_WORD);
            append(c);
            state = ST_NUMBER;
          end else if (c == CH_DOT) begin
            emit(CLS_WORD);
            append(c);
            state = ST_DOT;
          end else if (is_punct(c)) begin
            emit(CLS_WORD);
            append(c);
            emit(CLS_PUNCT);
            state = ST_START;
          end else begin
            raise_err();
          end
        end
        ST_NUMBER, ST_NUMDOT, ST_DOT: begin
          if (sign || expo || is_digit(c)) begin
            append(c);
            state = ST_NUMBER;
          end else if (c == CH_HASH) begin
            emit(CLS_NUMBER);
            state = ST_COMMENT;
          end else if (c == CH_QUOTE) begin
            // After a trailing dot the opening quote is not kept.
            emit(CLS_NUMBER);
            if (s != ST_NUMDOT) append(c);
            state = ST_STRING;
          end else if (c == CH_SPACE) begin
            emit(CLS_NUMBER);
            state = ST_START;
          end else if (is_ident(c)) begin
            emit(CLS_NUMBER);
            append(c);
            state = ST_WORD;
          end else if (c == CH_DOT) begin
            if (s == ST_NUMBER) begin
              append(c);
              state = ST_NUMDOT;
            end else begin
              if (s == ST_NUMDOT) split_last();
              append(c);
              state = ST_ELL2;
            end
          end else if (is_punct(c)) begin
            emit(CLS_NUMBER);
            append(c);
            emit(CLS_PUNCT);
            state = ST_START;
          end else begin
            raise_err();
          end
        end
        ST_ELL2: begin
          if (c == CH_DOT) begin
            append(c);
            emit(CLS_ELLIPSIS);
            state = ST_START;
          end else begin
            raise_err();
          end
        end
        ST_STRING: begin
          if (c == CH_QUOTE) begin
            append(c);
            emit(CLS_STRING);
            state = ST_START;
          end else if (c == CH_BSLASH) begin
            state = ST_ESCAPE;
          end else begin
            append(c);
          end
        end
        ST_ESCAPE: begin
          if (c == CH_QUOTE || c == CH_BSLASH) begin
            append(c);
            state = ST_STRING;
          end else begin
            raise_err();
          end
        end
        default: raise_err();
      endcase
      if (cur_col + 1 < MAX_COLUMNS) cur_col++;
    endfunction

    function void end_line();
      if (state == ST_STRING || state == ST_ESCAPE || state == ST_ELL2) begin
        raise_err();
        return;
      end
      if (tok_cnt > 0) begin
        if (state == ST_WORD) emit(CLS_WORD);
        else emit(CLS_NUMBER);
      end
      if (locked) return;
      state   = ST_START;
      tok_cnt = 0;
      tok_col = 0;
      cur_col = 0;
      if (cur_row + 1 >= MAX_ROWS) cur_row = 0;
      else cur_row++;
    endfunction

    // Runs one accepted item through the prediction and queues its results.
    function int note_input(logic [1:0] mode, logic [7:0] b);
      step_n = 0;
      if (mode == MODE_RESTART) begin
        reset_state();
        return 0;
      end
      if (mode == MODE_UNUSED || locked) return 0;
      if (mode == MODE_EOL) end_line();
      else if (b >= 8'd128) raise_err();
      else if (b == CH_TAB) repeat (4) lex_char(CH_SPACE);
      else if (b >= 8'd32) lex_char(b);
      if (step_n > 0) step_res[step_n-1].last = 1'b1;
      for (int i = 0; i < step_n; i++) expect_q.insert(expect_q.size(), step_res[i]);
      return step_n;
    endfunction

    function void check_result(logic [1:0] kind, logic [OUT_DATA_W-1:0] data, logic last);
      lex_item_t exp;
      if (expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d data %012h last %0d", kind, data, last);
        return;
      end
      exp = expect_q.pop_front();
      if (kind !== exp.res.kind || data[7:0] !== exp.res.data_byte ||
          data[10:8] !== exp.res.cls || data[26:11] !== exp.res.row ||
          data[36:27] !== exp.res.col || data[44:37] !== exp.res.len ||
          data[47:45] !== 3'd0 || last !== exp.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected kind %0d byte %02h class %0d row %0d col %0d len %0d last %0d",
                   exp.res.kind, exp.res.data_byte, exp.res.cls, exp.res.row,
                   exp.res.col, exp.res.len, exp.last);
          $display("          got      kind %0d byte %02h class %0d row %0d col %0d len %0d last %0d fill %0d",
                   kind, data[7:0], data[10:8], data[26:11], data[36:27], data[44:37],
                   last, data[47:45]);
        end
      end
    endfunction
  endclass

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata  = 8'h00;
  logic [1:0]            s_tuser  = MODE_CHAR;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  m_tlast;

  lexer_scoreboard sb = new();

  int cycles      = 0;
  int accepted    = 0;
  int burst_left  = 0;
  bit no_idle     = 1'b0;
  bit long_hold_go = 1'b0;
  int hold_left   = 0;
  int style       = 0;
  int style_left  = 0;
  int pattern_cnt = 0;

  string dot_forms [10] = '{".", "..", "...", "1..", "42...", "9.\"", ".5", ".e", "1.2.", ".x"};
  string punct_set = "[]{}=,";

  table_driven_token_lexer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("table_driven_token_lexer verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
      if (s_tvalid && s_tready) begin
        void'(sb.note_input(s_tuser, s_tdata));
        accepted++;
      end
    end
  end

  // Receiver: changes its stall style now and then, and takes one long
  // hold-off when the stimulus asks for it.
  always @(negedge clk) begin
    pattern_cnt++;
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (long_hold_go) begin
      long_hold_go = 1'b0;
      hold_left = LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        style = $urandom_range(0, 3);
        style_left = $urandom_range(16, 200);
      end
      style_left--;
      case (style)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (pattern_cnt % 4 != 3);
      endcase
    end
  end

  task automatic send(input logic [1:0] mode, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(60, 150);
      else burst_left = $urandom_range(1, 24);
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send(MODE_CHAR, s[i]);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] ident_char();
    int r;
    r = $urandom_range(0, 53);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return (r == 52) ? 8'("$") : 8'("_");
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 126)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] number_char();
    int r;
    r = $urandom_range(0, 11);
    case (r)
      8: return "e";
      9: return "E";
      10: return ($urandom_range(0, 1) == 0) ? 8'("+") : 8'("-");
      11: return CH_DOT;
      default: return digit_char();
    endcase
  endfunction

  task automatic gen_token();
    int pick;
    int n;
    int r;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      n = $urandom_range(1, 8);
      send(MODE_CHAR, ident_char());
      repeat (n - 1) send(MODE_CHAR, ($urandom_range(0, 2) == 0) ? digit_char() : ident_char());
    end else if (pick < 45) begin
      if ($urandom_range(0, 3) == 0) send(MODE_CHAR, ($urandom_range(0, 1) == 0) ? "+" : "-");
      else send(MODE_CHAR, digit_char());
      repeat ($urandom_range(0, 5)) send(MODE_CHAR, number_char());
    end else if (pick < 60) begin
      send(MODE_CHAR, CH_QUOTE);
      repeat ($urandom_range(0, 8)) begin
        r = $urandom_range(0, 7);
        if (r < 6) begin
          send(MODE_CHAR, text_char());
        end else if (r == 6) begin
          send(MODE_CHAR, CH_BSLASH);
          send(MODE_CHAR, ($urandom_range(0, 1) == 0) ? CH_QUOTE : CH_BSLASH);
        end else begin
          send(MODE_CHAR, CH_TAB);
        end
      end
      if ($urandom_range(0, 9) != 0) send(MODE_CHAR, CH_QUOTE);
    end else if (pick < 68) begin
      send(MODE_CHAR, punct_set[$urandom_range(0, 5)]);
    end else if (pick < 76) begin
      send_str(dot_forms[$urandom_range(0, 9)]);
    end else if (pick < 82) begin
      send(MODE_CHAR, CH_HASH);
      repeat ($urandom_range(0, 6)) send(MODE_CHAR, 8'($urandom_range(0, 127)));
      send(MODE_EOL, 8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      send(MODE_EOL, 8'($urandom_range(0, 255)));
    end else if (pick < 95) begin
      repeat ($urandom_range(1, 3)) begin
        r = $urandom_range(0, 2);
        send(MODE_CHAR, (r == 0) ? CH_TAB : (r == 1) ? CH_SPACE : 8'($urandom_range(0, 31)));
      end
    end else begin
      // Noise and broken sequences, most of which end in a syntax error.
      case ($urandom_range(0, 4))
        0: send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        1: begin
          send_str("\"\\");
          send(MODE_CHAR, ident_char());
        end
        2: begin
          send_str("\"ab");
          send(MODE_EOL, 8'h00);
        end
        3: begin
          send_str("..");
          send(MODE_EOL, 8'hFF);
        end
        default: send(MODE_CHAR, 8'($urandom_range(128, 255)));
      endcase
    end
    r = $urandom_range(0, 9);
    if (r >= 4 && r <= 6) send(MODE_CHAR, CH_SPACE);
    else if (r == 7) send(MODE_CHAR, CH_TAB);
    else if (r == 8) send(MODE_CHAR, 8'($urandom_range(0, 31)));
    else if (r == 9) send(MODE_EOL, 8'($urandom_range(0, 255)));
  endtask

  task automatic random_phase();
    bit held;
    bit paused;
    held   = 1'b0;
    paused = 1'b0;
    while (accepted < RANDOM_GOAL) begin
      if (sb.is_locked()) begin
        if ($urandom_range(0, 4) == 0)
          send(2'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        else
          send(MODE_RESTART, 8'($urandom_range(0, 255)));
      end else begin
        gen_token();
      end
      if (!held && accepted >= 120) begin
        // Keep offering a long word while the output is held off.
        held = 1'b1;
        send(MODE_RESTART, 8'h00);
        long_hold_go = 1'b1;
        no_idle = 1'b1;
        repeat (40) send(MODE_CHAR, ident_char());
        no_idle = 1'b0;
        send(MODE_CHAR, CH_SPACE);
      end
      if (!paused && accepted >= 230) begin
        paused = 1'b1;
        wait_drain();
      end
    end
  endtask

  task automatic directed_phase();
    send_str("a$9.=");
    send_str("1...");
    send_str(".#");
    send(MODE_EOL, 8'h00);
    send_str("7.\"\\\"\t\"");
    send(MODE_CHAR, 8'h00);
    send(MODE_UNUSED, 8'hA5);
    send(MODE_CHAR, "_");
    send(MODE_EOL, 8'h5A);
    send(MODE_CHAR, 8'hFF);
    send(MODE_CHAR, "a");
    send(MODE_EOL, 8'h00);
    send(MODE_RESTART, 8'hFF);
  endtask

  task automatic large_phase();
    send(MODE_RESTART, 8'h00);
    // A tab inside a string adds four characters: the first string closes
    // at exactly the longest token, the second runs two characters past it.
    send(MODE_CHAR, CH_QUOTE);
    repeat (63) send(MODE_CHAR, CH_TAB);
    send_str("a\"");
    send(MODE_CHAR, CH_SPACE);
    send(MODE_CHAR, CH_QUOTE);
    repeat (64) send(MODE_CHAR, CH_TAB);
    send(MODE_RESTART, 8'h00);
    send_str("w");
    send(MODE_EOL, 8'h00);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed_phase();
    wait_drain();
    random_phase();
    wait_drain();
    large_phase();
    wait_drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("table_driven_token_lexer verification clean");
    end else begin
      $display("table_driven_token_lexer verification failed");
    end
    $finish;
  end

endmodule
